FILE: rtl/tmr_pkg.sv
package tmr_pkg;

	localparam int TIME_BITS     = 48;
	localparam int INTERVAL_BITS = 32;
	localparam int GEN_BITS      = 32;

	localparam int ALU_BITS = (TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS;
	localparam int CNT_BITS = $clog2(TIME_BITS);

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	localparam logic [2:0] CMD_START_ONCE  = 3'd0;
	localparam logic [2:0] CMD_START_DELAY = 3'd1;
	localparam logic [2:0] CMD_START_RATE  = 3'd2;
	localparam logic [2:0] CMD_STOP        = 3'd3;
	localparam logic [2:0] CMD_POLL        = 3'd4;
	localparam logic [2:0] CMD_FINISH      = 3'd5;

	localparam logic [1:0] MODE_INACTIVE = 2'd0;
	localparam logic [1:0] MODE_ONCE     = 2'd1;
	localparam logic [1:0] MODE_DELAY    = 2'd2;
	localparam logic [1:0] MODE_RATE     = 2'd3;

	typedef struct packed {
		logic [2:0]                      command;
		logic [TIME_BITS-1:0]            now;
		logic signed [INTERVAL_BITS-1:0] interval;
		logic [GEN_BITS-1:0]             token_generation;
		logic [1:0]                      token_mode;
		logic [TIME_BITS-1:0]            token_due;
	} cmd_t;

	typedef struct packed {
		logic                 fired;
		logic [1:0]           fire_mode;
		logic [TIME_BITS-1:0] fire_due;
		logic [GEN_BITS-1:0]  fire_generation;
		logic                 param_error;
		logic                 reschedule;
		logic                 busy_res;
		logic [1:0]           current_mode;
		logic                 wake_valid;
		logic [TIME_BITS-1:0] next_wake;
		logic                 token_pending;
	} res_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] sum_sat;
		logic [ALU_BITS-1:0]  diff;
		logic                 lt;
	} alu_res_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_stat_t;

endpackage

FILE: rtl/tmr_alu.sv
module tmr_alu (
	input  logic [tmr_pkg::ALU_BITS-1:0] a,
	input  logic [tmr_pkg::ALU_BITS-1:0] b,
	output tmr_pkg::alu_res_t            res
);

	logic [tmr_pkg::ALU_BITS:0] sum;
	logic [tmr_pkg::ALU_BITS:0] dif;

	always_comb begin
		sum = {1'b0, a} + {1'b0, b};
		dif = {1'b0, a} - {1'b0, b};
		if (sum > (tmr_pkg::ALU_BITS+1)'(tmr_pkg::TIME_MAX)) begin
			res.sum_sat = tmr_pkg::TIME_MAX;
		end else begin
			res.sum_sat = sum[tmr_pkg::TIME_BITS-1:0];
		end
		res.diff = dif[tmr_pkg::ALU_BITS-1:0];
		res.lt   = dif[tmr_pkg::ALU_BITS];
	end

endmodule

FILE: rtl/tmr_core.sv
module tmr_core (
	input  logic                clk,
	input  logic                arst_n,
	input  tmr_pkg::cmd_t       cmd,
	input  logic                cmd_take,
	input  logic                out_free,
	output tmr_pkg::core_stat_t stat,
	output tmr_pkg::res_t       res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC,
		ST_CMP,
		ST_DIV,
		ST_BACK,
		ST_ADD,
		ST_DONE
	} state_t;

	state_t                               state_q;
	tmr_pkg::cmd_t                        in_q;
	logic                                 armed_q;
	logic                                 pend_q;
	logic [1:0]                           mode_q;
	logic [tmr_pkg::INTERVAL_BITS-1:0]    period_q;
	logic [tmr_pkg::TIME_BITS-1:0]        wake_q;
	logic [tmr_pkg::TIME_BITS-1:0]        last_due_q;
	logic [tmr_pkg::GEN_BITS-1:0]         gen_q;
	logic                                 fired_q;
	logic                                 perr_q;
	logic                                 resched_q;
	logic [tmr_pkg::TIME_BITS-1:0]        nx_q;
	logic [tmr_pkg::ALU_BITS-1:0]         rem_q;
	logic [tmr_pkg::TIME_BITS-1:0]        div_q;
	logic [tmr_pkg::CNT_BITS-1:0]         cnt_q;

	logic [tmr_pkg::ALU_BITS-1:0] alu_a;
	logic [tmr_pkg::ALU_BITS-1:0] alu_b;
	tmr_pkg::alu_res_t            alu;
	logic [tmr_pkg::ALU_BITS-1:0] trial;
	logic                         ival_pos;
	logic                         match;

	tmr_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu)
	);

	assign ival_pos = (in_q.interval != '0) && !in_q.interval[tmr_pkg::INTERVAL_BITS-1];
	assign match    = pend_q && (gen_q == in_q.token_generation) && (mode_q == in_q.token_mode);
	assign trial    = {rem_q[tmr_pkg::ALU_BITS-2:0], div_q[tmr_pkg::TIME_BITS-1]};

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			ST_DEC: begin
				case (in_q.command)
					tmr_pkg::CMD_START_ONCE, tmr_pkg::CMD_START_DELAY,
					tmr_pkg::CMD_START_RATE: begin
						alu_a = tmr_pkg::ALU_BITS'(in_q.now);
						alu_b = tmr_pkg::ALU_BITS'($unsigned(in_q.interval));
					end
					tmr_pkg::CMD_POLL: begin
						alu_a = tmr_pkg::ALU_BITS'(in_q.now);
						alu_b = tmr_pkg::ALU_BITS'(wake_q);
					end
					tmr_pkg::CMD_FINISH: begin
						if (mode_q == tmr_pkg::MODE_DELAY) begin
							alu_a = tmr_pkg::ALU_BITS'(in_q.now);
						end else begin
							alu_a = tmr_pkg::ALU_BITS'(in_q.token_due);
						end
						alu_b = tmr_pkg::ALU_BITS'(period_q);
					end
					default: begin
						alu_a = '0;
						alu_b = '0;
					end
				endcase
			end
			ST_CMP: begin
				alu_a = tmr_pkg::ALU_BITS'(in_q.now);
				alu_b = tmr_pkg::ALU_BITS'(nx_q);
			end
			ST_DIV: begin
				alu_a = trial;
				alu_b = tmr_pkg::ALU_BITS'(period_q);
			end
			ST_BACK: begin
				alu_a = tmr_pkg::ALU_BITS'(in_q.now);
				alu_b = rem_q;
			end
			ST_ADD: begin
				alu_a = tmr_pkg::ALU_BITS'(nx_q);
				alu_b = tmr_pkg::ALU_BITS'(period_q);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_q       <= '0;
			armed_q    <= 1'b0;
			pend_q     <= 1'b0;
			mode_q     <= tmr_pkg::MODE_INACTIVE;
			period_q   <= '0;
			wake_q     <= '0;
			last_due_q <= '0;
			gen_q      <= '0;
			fired_q    <= 1'b0;
			perr_q     <= 1'b0;
			resched_q  <= 1'b0;
			nx_q       <= '0;
			rem_q      <= '0;
			div_q      <= '0;
			cnt_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						in_q      <= cmd;
						fired_q   <= 1'b0;
						perr_q    <= 1'b0;
						resched_q <= 1'b0;
						state_q   <= ST_DEC;
					end
				end
				ST_DEC: begin
					state_q <= ST_DONE;
					case (in_q.command)
						tmr_pkg::CMD_START_ONCE, tmr_pkg::CMD_START_DELAY,
						tmr_pkg::CMD_START_RATE: begin
							if (in_q.command != tmr_pkg::CMD_START_ONCE && !ival_pos) begin
								perr_q <= 1'b1;
							end else begin
								if (in_q.command == tmr_pkg::CMD_START_ONCE) begin
									mode_q <= tmr_pkg::MODE_ONCE;
								end else if (in_q.command == tmr_pkg::CMD_START_DELAY) begin
									mode_q <= tmr_pkg::MODE_DELAY;
								end else begin
									mode_q <= tmr_pkg::MODE_RATE;
								end
								period_q  <= $unsigned(in_q.interval);
								wake_q    <= ival_pos ? alu.sum_sat : in_q.now;
								armed_q   <= 1'b1;
								pend_q    <= 1'b0;
								gen_q     <= gen_q + 1'b1;
								resched_q <= 1'b1;
							end
						end
						tmr_pkg::CMD_STOP: begin
							armed_q <= 1'b0;
							pend_q  <= 1'b0;
							mode_q  <= tmr_pkg::MODE_INACTIVE;
							gen_q   <= gen_q + 1'b1;
						end
						tmr_pkg::CMD_POLL: begin
							if (armed_q && !alu.lt) begin
								armed_q    <= 1'b0;
								pend_q     <= 1'b1;
								last_due_q <= wake_q;
								fired_q    <= 1'b1;
							end
						end
						tmr_pkg::CMD_FINISH: begin
							pend_q <= 1'b0;
							if (match) begin
								if (mode_q == tmr_pkg::MODE_DELAY) begin
									wake_q    <= alu.sum_sat;
									armed_q   <= 1'b1;
									resched_q <= 1'b1;
								end else if (mode_q == tmr_pkg::MODE_RATE) begin
									nx_q <= alu.sum_sat;
									if (period_q == '0) begin
										wake_q    <= tmr_pkg::TIME_MAX;
										armed_q   <= 1'b1;
										resched_q <= 1'b1;
									end else begin
										state_q <= ST_CMP;
									end
								end else begin
									mode_q <= tmr_pkg::MODE_INACTIVE;
								end
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_CMP: begin
					if (!alu.lt && nx_q != tmr_pkg::TIME_MAX) begin
						div_q   <= alu.diff[tmr_pkg::TIME_BITS-1:0];
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						wake_q    <= nx_q;
						armed_q   <= 1'b1;
						resched_q <= 1'b1;
						state_q   <= ST_DONE;
					end
				end
				ST_DIV: begin
					rem_q <= alu.lt ? trial : alu.diff;
					div_q <= {div_q[tmr_pkg::TIME_BITS-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tmr_pkg::CNT_BITS'(tmr_pkg::TIME_BITS - 1)) begin
						state_q <= ST_BACK;
					end
				end
				ST_BACK: begin
					nx_q    <= alu.diff[tmr_pkg::TIME_BITS-1:0];
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					wake_q    <= alu.sum_sat;
					armed_q   <= 1'b1;
					resched_q <= 1'b1;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		stat.idle = (state_q == ST_IDLE);
		stat.done = (state_q == ST_DONE);

		res.fired           = fired_q;
		res.fire_mode       = fired_q ? mode_q : tmr_pkg::MODE_INACTIVE;
		res.fire_due        = fired_q ? last_due_q : '0;
		res.fire_generation = fired_q ? gen_q : '0;
		res.param_error     = perr_q;
		res.reschedule      = resched_q;
		res.busy_res        = armed_q || pend_q;
		res.current_mode    = mode_q;
		res.wake_valid      = armed_q;
		res.next_wake       = armed_q ? wake_q : '0;
		res.token_pending   = match;
	end

endmodule

FILE: rtl/one_shot_and_periodic_event_timer.sv
// Event timer with one-shot, fixed-delay and fixed-rate modes.
// Commands come in on the cmd channel (cmd_valid/cmd_ready), one item per
// command: start once, start fixed-delay, start fixed-rate, stop, poll or
// finish. Each item produces exactly one result item on the res channel
// (res_valid/res_ready) that carries firing data, error and reschedule flags
// and the timer state after the command.
// Start, stop, poll and most finish commands pass through the decode and done
// states before their result is registered; the sequencer takes no new item
// until that result has gone to the output register and it is idle again.
// A matching fixed-rate finish passes through a further compare state that
// checks the next due time against now. One that has to catch up over missed
// periods then computes the remainder of the elapsed time by the period one bit
// per cycle on the shared adder.
// cmd_ready is high only while the sequencer is idle. A result waits in the
// output register until taken; the next command is still accepted meanwhile,
// and the sequencer holds its following result until the register is free.
// Reset clears the timer to inactive with generation zero and empties the
// output register; no result is pending after reset.
module one_shot_and_periodic_event_timer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tmr_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output tmr_pkg::res_t res
);

	tmr_pkg::core_stat_t stat;
	tmr_pkg::res_t       core_res;
	tmr_pkg::res_t       res_q;
	logic                res_valid_q;
	logic                cmd_take;
	logic                out_free;

	assign cmd_ready = stat.idle;
	assign cmd_take  = cmd_valid && cmd_ready;
	assign out_free  = !res_valid_q || res_ready;

	tmr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_take (cmd_take),
		.out_free (out_free),
		.stat     (stat),
		.res      (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (stat.done && out_free) begin
				res_valid_q <= 1'b1;
				res_q       <= core_res;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while sequencer stayed idle");

	a_fire_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.fired |-> res.fire_due == '0 && res.fire_generation == '0)
		else $error("firing data present without a firing");

	a_error_no_resched: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.param_error |-> !res.reschedule)
		else $error("rejected start reported a reschedule");

	a_fire_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.fired |-> !res.wake_valid && res.busy_res)
		else $error("fired timer still armed or not pending");
`endif

endmodule
